[src/tcp_flow_table_tracker_assert.svh]
// Assertion macros for the flow table tracker
`ifndef TCP_FLOW_TABLE_TRACKER_ASSERT_SVH
`define TCP_FLOW_TABLE_TRACKER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset
`define TFT_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tft assertion failed");
// Next-cycle implication checked outside reset
`define TFT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tft assertion failed");
`endif

[src/tft_pkg.sv]
// Package: types, constants and codes for the flow table tracker
`default_nettype none
package tft_pkg;
  localparam int unsigned TableEntries = 64;
  localparam int unsigned IdxBits = $clog2(TableEntries);
  localparam int unsigned CountBits = 32;
  // every entry has its own comparator, so the scan takes one step
  localparam int unsigned ScanLanes = TableEntries;
  localparam int unsigned ScanSteps = TableEntries / ScanLanes;
  localparam int unsigned StepBits = (ScanSteps > 1) ? $clog2(ScanSteps) : 1;
  localparam int unsigned LaneBits = $clog2(ScanLanes);
  localparam logic [63:0] NsPerMs = 64'd1000000;
  localparam int unsigned MsBits = 45;

  // 2^32 ns = WordMs ms + WordRemNs ns, used to fold the upper word down
  localparam logic [12:0] WordMs = 13'((64'd1 << 32) / NsPerMs);
  localparam logic [19:0] WordRemNs = 20'((64'd1 << 32) % NsPerMs);
  // x / 1e6 == (x * RecipMul) >> RecipShift for any 32-bit x
  localparam int unsigned RecipShift = 50;
  localparam logic [31:0] RecipMul = 32'(((64'd1 << RecipShift) + NsPerMs - 64'd1) / NsPerMs);

  typedef enum logic [1:0] {
    STATUS_COUNTED = 2'd0,
    STATUS_CLOSED  = 2'd1,
    STATUS_DROPPED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_UPDATE, ST_DIVIDE, ST_OUTPUT
  } state_e;

  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  header_flags;
    logic [63:0] arrival_time_ns;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] side_a_address;
    logic [15:0] side_a_port;
    logic [31:0] side_b_address;
    logic [15:0] side_b_port;
    logic [31:0] packets_toward_a;
    logic [31:0] packets_from_a;
    logic [44:0] lifetime_ms;
  } out_beat_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic update;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic scan_last;
    logic hit;
    logic free;
    logic closing;
    logic div_done;
  } stat_t;
endpackage
`default_nettype wire

[src/tft_datapath.sv]
// Datapath: key normalize, table scan, entry update, ms divider, output register
`default_nettype none
module tft_datapath import tft_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire in_beat_t  in_data_i,
  input  wire cmd_t      cmd_i,
  output stat_t          stat_o,
  output out_beat_t      out_data_o
);
  // Entry storage: valid bits in flops, payload in arrays
  logic [TableEntries-1:0] valid_q;
  logic [31:0] a_addr_mem [TableEntries];
  logic [15:0] a_port_mem [TableEntries];
  logic [31:0] b_addr_mem [TableEntries];
  logic [15:0] b_port_mem [TableEntries];
  logic [63:0] start_mem  [TableEntries];
  logic [CountBits-1:0] cin_mem  [TableEntries];
  logic [CountBits-1:0] cout_mem [TableEntries];

  in_beat_t pkt_q;
  logic [31:0] a_addr_q, b_addr_q;
  logic [15:0] a_port_q, b_port_q;
  logic from_a_q;
  logic [StepBits-1:0] step_q;
  logic hit_q, free_q;
  logic [IdxBits-1:0] hit_idx_q, free_idx_q;
  logic [63:0] start_rd_q;
  logic [CountBits-1:0] cin_rd_q, cout_rd_q;
  logic [63:0] rem_q;
  logic [MsBits-1:0] quo_q;
  logic [31:0] rep_in_q, rep_out_q;
  out_beat_t out_q;

  // Key normalization on the incoming beat
  logic src_is_a;
  assign src_is_a = (in_data_i.source_address < in_data_i.dest_address) ||
                    ((in_data_i.source_address == in_data_i.dest_address) &&
                     (in_data_i.source_port < in_data_i.dest_port));

  // One group of lanes compared per scan step
  logic lane_hit, lane_free;
  logic [LaneBits-1:0] lane_hit_idx, lane_free_idx;
  always_comb begin
    logic [IdxBits-1:0] e;
    lane_hit = 1'b0;
    lane_free = 1'b0;
    lane_hit_idx = '0;
    lane_free_idx = '0;
    for (int l = ScanLanes - 1; l >= 0; l--) begin
      e = IdxBits'(step_q * ScanLanes + l);
      if (valid_q[e]) begin
        if (a_addr_mem[e] == a_addr_q && a_port_mem[e] == a_port_q &&
            b_addr_mem[e] == b_addr_q && b_port_mem[e] == b_port_q) begin
          lane_hit = 1'b1;
          lane_hit_idx = LaneBits'(l);
        end
      end else begin
        lane_free = 1'b1;
        lane_free_idx = LaneBits'(l);
      end
    end
  end

  logic [IdxBits-1:0] lane_slot;
  assign lane_slot = IdxBits'(step_q * ScanLanes + lane_hit_idx);

  logic [IdxBits-1:0] slot;
  assign slot = hit_q ? hit_idx_q : free_idx_q;

  // Saturating counts for the updated entry
  logic [CountBits-1:0] cin_cur, cout_cur, cin_nx, cout_nx;
  assign cin_cur  = hit_q ? cin_rd_q  : '0;
  assign cout_cur = hit_q ? cout_rd_q : '0;
  assign cin_nx  = (!from_a_q && cin_cur != '1) ? cin_cur + 1'b1 : cin_cur;
  assign cout_nx = (from_a_q && cout_cur != '1) ? cout_cur + 1'b1 : cout_cur;
  logic [63:0] start_cur;
  assign start_cur = hit_q ? start_rd_q : pkt_q.arrival_time_ns;

  // Divide by 1e6: fold the upper word down, then a reciprocal multiply
  logic [51:0] fold_rem;
  logic [MsBits-1:0] fold_quo;
  logic [63:0] recip_prod;
  logic [MsBits-1:0] ms_total;
  assign fold_rem = {20'd0, rem_q[63:32]} * {32'd0, WordRemNs};
  assign fold_quo = {13'd0, rem_q[63:32]} * {32'd0, WordMs};
  assign recip_prod = {32'd0, rem_q[31:0]} * {32'd0, RecipMul};
  assign ms_total = quo_q + MsBits'(recip_prod[63:RecipShift]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      step_q  <= '0;
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
    end else begin
      if (cmd_i.scan_start) begin
        step_q <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        step_q <= step_q + 1'b1;
        if (!hit_q && lane_hit) begin
          hit_q <= 1'b1;
          hit_idx_q <= lane_slot;
        end
        if (!free_q && lane_free) begin
          free_q <= 1'b1;
          free_idx_q <= IdxBits'(step_q * ScanLanes + lane_free_idx);
        end
      end
      if (cmd_i.update) begin
        valid_q[slot] <= !(|(pkt_q.header_flags & 8'h05));
      end
    end
  end

  // Packet capture, entry read and write, divider and output
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pkt_q <= in_data_i;
      from_a_q <= src_is_a ||
        (in_data_i.source_address == in_data_i.dest_address &&
         in_data_i.source_port == in_data_i.dest_port);
      a_addr_q <= src_is_a ? in_data_i.source_address : in_data_i.dest_address;
      a_port_q <= src_is_a ? in_data_i.source_port : in_data_i.dest_port;
      b_addr_q <= src_is_a ? in_data_i.dest_address : in_data_i.source_address;
      b_port_q <= src_is_a ? in_data_i.dest_port : in_data_i.source_port;
    end
    // registered read of the matching entry
    if (cmd_i.scan_step && !hit_q && lane_hit) begin
      start_rd_q <= start_mem[lane_slot];
      cin_rd_q   <= cin_mem[lane_slot];
      cout_rd_q  <= cout_mem[lane_slot];
    end
    if (cmd_i.update) begin
      a_addr_mem[slot] <= a_addr_q;
      a_port_mem[slot] <= a_port_q;
      b_addr_mem[slot] <= b_addr_q;
      b_port_mem[slot] <= b_port_q;
      start_mem[slot]  <= start_cur;
      cin_mem[slot]    <= cin_nx;
      cout_mem[slot]   <= cout_nx;
      rep_in_q  <= 32'(cin_nx);
      rep_out_q <= 32'(cout_nx);
      rem_q <= (pkt_q.arrival_time_ns >= start_cur) ?
               pkt_q.arrival_time_ns - start_cur : 64'd0;
    end
    if (cmd_i.div_start) begin
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= {12'd0, fold_rem} + {32'd0, rem_q[31:0]};
      quo_q <= quo_q + fold_quo;
    end
    if (cmd_i.out_load) begin
      out_q <= '0;
      if (!hit_q && !free_q) begin
        out_q.status <= STATUS_DROPPED;
      end else if (|(pkt_q.header_flags & 8'h05)) begin
        out_q.status <= STATUS_CLOSED;
        out_q.side_a_address <= a_addr_q;
        out_q.side_a_port <= a_port_q;
        out_q.side_b_address <= b_addr_q;
        out_q.side_b_port <= b_port_q;
        out_q.packets_toward_a <= rep_in_q;
        out_q.packets_from_a <= rep_out_q;
        out_q.lifetime_ms <= (ms_total == '0) ? MsBits'(1) : ms_total;
      end else begin
        out_q.status <= STATUS_COUNTED;
      end
    end
  end

  assign stat_o.scan_last = (step_q == StepBits'(ScanSteps - 1));
  assign stat_o.hit = hit_q;
  assign stat_o.free = free_q;
  assign stat_o.closing = |(pkt_q.header_flags & 8'h05);
  assign stat_o.div_done = ~|rem_q[63:32];
  assign out_data_o = out_q;
endmodule
`default_nettype wire

[src/tft_ctrl.sv]
// Controller: sequences scan, update, divide and output handshake
`default_nettype none
module tft_ctrl import tft_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);
  `include "tcp_flow_table_tracker_assert.svh"
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cmd_o.scan_start = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (stat_i.hit || stat_i.free) begin
          cmd_o.update = 1'b1;
          if (stat_i.closing) begin
            cmd_o.div_start = 1'b1;
            state_d = ST_DIVIDE;
          end else begin
            cmd_o.out_load = 1'b1;
            state_d = ST_OUTPUT;
          end
        end else begin
          cmd_o.out_load = 1'b1;
          state_d = ST_OUTPUT;
        end
      end
      ST_DIVIDE: begin
        if (stat_i.div_done) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_OUTPUT;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_OUTPUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `TFT_ASSERT_IMPLY(a_no_accept_busy, state_q != ST_IDLE, in_stall_o)
  `TFT_ASSERT_IMPLY(a_one_update, cmd_o.update, state_q == ST_UPDATE)
  `TFT_ASSERT_NEXT(a_accept_scans, in_valid_i && !in_stall_o, state_q == ST_SCAN)
  `TFT_ASSERT_NEXT(a_out_held, out_valid_o && out_stall_i, out_valid_o)
endmodule
`default_nettype wire

[src/tcp_flow_table_tracker.sv]
// Top level of the TCP flow table tracker
// One packet header at a time: all 64 entries are compared in parallel during the scan, then
// the matching or a free entry is updated; a closing packet then divides by 1e6 by folding
// the upper word of the elapsed time down until it is zero, and a reciprocal multiply on the
// lower word is loaded into the output register; the result beat is held until taken.
// No reset clearing pass.
`default_nettype none
module tcp_flow_table_tracker import tft_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_beat_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_beat_t      out_data_o
);
  cmd_t  cmd;
  stat_t stat;

  tft_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  tft_datapath u_dp (
    .clk_i, .rst_ni, .in_data_i, .cmd_i(cmd), .stat_o(stat), .out_data_o
  );
endmodule
`default_nettype wire

[bench/tb_top.sv]
// Self-checking testbench for the TCP flow table tracker
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import tft_pkg::*;

  localparam int unsigned NumRandom = 700;
  localparam int unsigned NumFlows = 96;
  localparam logic [31:0] CountMax = 32'hFFFF_FFFF;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_data_o;

  tcp_flow_table_tracker dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow flow table
  logic        flow_used [TableEntries];
  logic [31:0] flow_a_addr [TableEntries];
  logic [15:0] flow_a_port [TableEntries];
  logic [31:0] flow_b_addr [TableEntries];
  logic [15:0] flow_b_port [TableEntries];
  logic [63:0] flow_start [TableEntries];
  logic [31:0] flow_in [TableEntries];
  logic [31:0] flow_out [TableEntries];

  out_beat_t pending_summaries[$];
  out_beat_t typed_summaries[$];
  int unsigned errors = 0;
  int unsigned n_closed = 0, n_dropped = 0, n_counted = 0;
  int unsigned beats_sent = 0;
  logic sending_done = 1'b0;
  logic calm = 1'b0;

  function automatic out_beat_t track_packet(in_beat_t p);
    out_beat_t r;
    logic src_low;
    logic [31:0] a_addr, b_addr;
    logic [15:0] a_port, b_port;
    logic [63:0] elapsed, ms;
    int hit, free_idx;
    r = '0;
    hit = -1;
    free_idx = -1;
    src_low = (p.source_address < p.dest_address) ||
              (p.source_address == p.dest_address && p.source_port < p.dest_port);
    if (src_low) begin
      a_addr = p.source_address; a_port = p.source_port;
      b_addr = p.dest_address;   b_port = p.dest_port;
    end else begin
      a_addr = p.dest_address;   a_port = p.dest_port;
      b_addr = p.source_address; b_port = p.source_port;
    end
    for (int i = 0; i < TableEntries; i++) begin
      if (flow_used[i]) begin
        if (hit < 0 && flow_a_addr[i] == a_addr && flow_a_port[i] == a_port &&
            flow_b_addr[i] == b_addr && flow_b_port[i] == b_port) hit = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (hit < 0) begin
      if (free_idx < 0) begin
        r.status = STATUS_DROPPED;
        return r;
      end
      hit = free_idx;
      flow_used[hit] = 1'b1;
      flow_a_addr[hit] = a_addr; flow_a_port[hit] = a_port;
      flow_b_addr[hit] = b_addr; flow_b_port[hit] = b_port;
      flow_start[hit] = p.arrival_time_ns;
      flow_in[hit] = '0;
      flow_out[hit] = '0;
    end
    if (p.source_address == a_addr && p.source_port == a_port &&
        p.dest_address == b_addr && p.dest_port == b_port) begin
      if (flow_out[hit] != CountMax) flow_out[hit]++;
    end else begin
      if (flow_in[hit] != CountMax) flow_in[hit]++;
    end
    // FIN or RST closes the flow
    if (!p.header_flags[0] && !p.header_flags[2]) begin
      r.status = STATUS_COUNTED;
      return r;
    end
    elapsed = (p.arrival_time_ns >= flow_start[hit]) ?
              p.arrival_time_ns - flow_start[hit] : 64'd0;
    ms = elapsed / NsPerMs;
    if (ms == 0) ms = 1;
    r.status = STATUS_CLOSED;
    r.side_a_address = flow_a_addr[hit];
    r.side_a_port = flow_a_port[hit];
    r.side_b_address = flow_b_addr[hit];
    r.side_b_port = flow_b_port[hit];
    r.packets_toward_a = flow_in[hit];
    r.packets_from_a = flow_out[hit];
    r.lifetime_ms = ms[44:0];
    flow_used[hit] = 1'b0;
    return r;
  endfunction

  // Input acceptance: predict, or take the typed-in expectation if one is queued
  always @(posedge clk_i) begin
    out_beat_t exp_r;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      exp_r = track_packet(in_data_i);
      if (typed_summaries.size() > 0) exp_r = typed_summaries.pop_front();
      pending_summaries.push_back(exp_r);
    end
  end

  // Output check
  always @(posedge clk_i) begin
    out_beat_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_summaries.size() == 0) begin
        $error("result beat with nothing expected: %p", out_data_o);
        errors++;
      end else begin
        e = pending_summaries.pop_front();
        case (out_data_o.status)
          STATUS_CLOSED:  n_closed++;
          STATUS_DROPPED: n_dropped++;
          default:        n_counted++;
        endcase
        if (out_data_o.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_data_o.status); errors++;
        end
        if (out_data_o.side_a_address !== e.side_a_address) begin
          $error("side_a_address exp %h got %h", e.side_a_address,
                 out_data_o.side_a_address); errors++;
        end
        if (out_data_o.side_a_port !== e.side_a_port) begin
          $error("side_a_port exp %h got %h", e.side_a_port, out_data_o.side_a_port);
          errors++;
        end
        if (out_data_o.side_b_address !== e.side_b_address) begin
          $error("side_b_address exp %h got %h", e.side_b_address,
                 out_data_o.side_b_address); errors++;
        end
        if (out_data_o.side_b_port !== e.side_b_port) begin
          $error("side_b_port exp %h got %h", e.side_b_port, out_data_o.side_b_port);
          errors++;
        end
        if (out_data_o.packets_toward_a !== e.packets_toward_a) begin
          $error("packets_toward_a exp %0d got %0d", e.packets_toward_a,
                 out_data_o.packets_toward_a); errors++;
        end
        if (out_data_o.packets_from_a !== e.packets_from_a) begin
          $error("packets_from_a exp %0d got %0d", e.packets_from_a,
                 out_data_o.packets_from_a); errors++;
        end
        if (out_data_o.lifetime_ms !== e.lifetime_ms) begin
          $error("lifetime_ms exp %0d got %0d", e.lifetime_ms, out_data_o.lifetime_ms);
          errors++;
        end
      end
    end
  end

  // Receiver: random stalls, a calm stretch, and one long hold-off
  initial begin
    int unsigned cyc;
    cyc = 0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc >= 1000 && cyc < 1400) out_stall_i <= 1'b1;
      else if (calm) out_stall_i <= 1'b0;
      else out_stall_i <= ($urandom_range(99) < 25);
    end
  end

  // Offer one beat; valid stays high into the next beat when no gap is drawn
  task automatic send_packet(in_beat_t p);
    if (!calm && $urandom_range(99) < 25) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= p;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    beats_sent++;
  endtask

  typedef struct packed {
    in_beat_t  pkt;
    logic      typed;
    out_beat_t want;
  } stim_row_t;

  function automatic in_beat_t mk(logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
                                  logic [15:0] dp, logic [7:0] fl, logic [63:0] t);
    in_beat_t p;
    p.source_address = sa; p.dest_address = da;
    p.source_port = sp; p.dest_port = dp;
    p.header_flags = fl; p.arrival_time_ns = t;
    return p;
  endfunction

  function automatic out_beat_t summary(logic [31:0] aa, logic [15:0] ap, logic [31:0] ba,
                                        logic [15:0] bp, logic [31:0] cin,
                                        logic [31:0] cout, logic [44:0] ms);
    out_beat_t r;
    r.status = STATUS_CLOSED;
    r.side_a_address = aa; r.side_a_port = ap;
    r.side_b_address = ba; r.side_b_port = bp;
    r.packets_toward_a = cin; r.packets_from_a = cout;
    r.lifetime_ms = ms;
    return r;
  endfunction

  // Flow pool for the random part: small address space so orderings tie often
  logic [31:0] pool_addr [NumFlows][2];
  logic [15:0] pool_port [NumFlows][2];

  initial begin
    stim_row_t rows[$];
    in_beat_t p;
    logic [63:0] now;
    int k, d;
    for (int i = 0; i < TableEntries; i++) flow_used[i] = 1'b0;

    // Directed rows
    rows.push_back('{mk(32'd1, 32'd2, 16'd10, 16'd20, 8'h02, 64'd0), 1'b1, '0});
    rows.push_back('{mk(32'd2, 32'd1, 16'd20, 16'd10, 8'h11, 64'd5_000_000), 1'b1,
                     summary(32'd1, 16'd10, 32'd2, 16'd20, 32'd1, 32'd1, 45'd5)});
    // new flow closed at once, extreme fields
    rows.push_back('{mk(32'hFFFF_FFFF, 32'd0, 16'hFFFF, 16'h0000, 8'h04, '1), 1'b1,
                     summary(32'd0, 16'd0, 32'hFFFF_FFFF, 16'hFFFF, 32'd1, 32'd0, 45'd1)});
    // equal endpoints: counted as sent by A
    rows.push_back('{mk(32'd7, 32'd7, 16'd7, 16'd7, 8'h01, 64'd99), 1'b1,
                     summary(32'd7, 16'd7, 32'd7, 16'd7, 32'd0, 32'd1, 45'd1)});
    // same address, port breaks the tie
    rows.push_back('{mk(32'd9, 32'd9, 16'd80, 16'd5, 8'hFA, 64'd1000), 1'b1, '0});
    rows.push_back('{mk(32'd9, 32'd9, 16'd5, 16'd80, 8'h00, 64'd2000), 1'b0, '0});
    rows.push_back('{mk(32'd9, 32'd9, 16'd80, 16'd5, 8'hFF, 64'd3_000_999_999), 1'b0, '0});
    // time going backwards
    rows.push_back('{mk(32'hC0A8_0001, 32'h0A00_0001, 16'd443, 16'd5555, 8'h02,
                        64'd1_000_000_000), 1'b0, '0});
    rows.push_back('{mk(32'h0A00_0001, 32'hC0A8_0001, 16'd5555, 16'd443, 8'h04, 64'd5),
                     1'b1, summary(32'h0A00_0001, 16'd5555, 32'hC0A8_0001, 16'd443,
                                   32'd1, 32'd1, 45'd1)});
    // widest duration
    rows.push_back('{mk(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF, 8'h00, 64'd0),
                     1'b0, '0});
    rows.push_back('{mk(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF, 8'h01,
                        64'hFFFF_FFFF_FFFF_FFFF), 1'b0, '0});
    rows.push_back('{mk(32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA, 8'h55,
                        64'h5555_5555_5555_5555), 1'b0, '0});

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].typed) typed_summaries.push_back(rows[i].want);
      send_packet(rows[i].pkt);
    end

    for (int i = 0; i < NumFlows; i++) begin
      for (int s = 0; s < 2; s++) begin
        pool_addr[i][s] = (i % 3 == 0) ? $urandom() : $urandom_range(7);
        pool_port[i][s] = (i % 4 == 0) ? 16'($urandom()) : 16'($urandom_range(3));
      end
    end

    // Random traffic over the pool, with full-range noise mixed in
    now = 64'd0;
    for (int n = 0; n < NumRandom; n++) begin
      calm = (n >= 250 && n < 400);
      // a burst of fresh flows in the middle overfills the table
      k = (n >= 450 && n < 540) ? (n - 450) % NumFlows : $urandom_range(NumFlows - 1);
      d = $urandom_range(1);
      if ($urandom_range(99) < 5) now = {$urandom(), $urandom()};
      else now = now + $urandom_range(30_000_000);
      p = mk(pool_addr[k][d], pool_addr[k][1 - d], pool_port[k][d], pool_port[k][1 - d],
             8'($urandom()) & 8'hFA, now);
      if ($urandom_range(99) < ((n >= 450 && n < 540) ? 2 : 12))
        p.header_flags[$urandom_range(1) ? 0 : 2] = 1'b1;
      if ($urandom_range(99) < 12)
        p = mk($urandom(), $urandom(), 16'($urandom()), 16'($urandom()),
               8'($urandom()), {$urandom(), $urandom()});
      send_packet(p);
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;
    sending_done = 1'b1;
  end

  // End of run
  initial begin
    wait (sending_done);
    while (pending_summaries.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("%0d packets: %0d counted, %0d closed with summary, %0d dropped on a full table",
             beats_sent, n_counted, n_closed, n_dropped);
    if (errors == 0 && pending_summaries.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
